>>> sv/ikslew_pkg.sv
// Shared types, constants and tables of the two-link arm joint controller.
package ikslew_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int SQRT_STEPS   = 18;
  localparam int DIV_STEPS    = 16;
  localparam int CNT_W        = 5;

  // Angles inside the datapath are in 1/16384 degree.
  localparam logic signed [23:0] ANG_90  = 24'sd1474560;
  localparam logic signed [23:0] ANG_180 = 24'sd2949120;

  // Hand offset in y: -0.2 rounds to -51/256, subtracted from the target.
  localparam logic signed [17:0] Y_OFFSET = 18'sd51;

  localparam logic [19:0] ATAN_TAB [TAB_LEN] = '{
    20'd737280, 20'd435242, 20'd229970, 20'd116736, 20'd58595, 20'd29326,
    20'd14667,  20'd7334,   20'd3667,   20'd1833,   20'd917,   20'd458,
    20'd229,    20'd115,    20'd57,     20'd29,     20'd14,    20'd7,
    20'd4,      20'd2,      20'd1,      20'd0,      20'd0,     20'd0
  };

  typedef enum logic [2:0] {
    CFG_BASE_X       = 3'd0,
    CFG_BASE_Y       = 3'd1,
    CFG_BASE_Z       = 3'd2,
    CFG_UPPER_LENGTH = 3'd3,
    CFG_FORE_LENGTH  = 3'd4,
    CFG_HAND_LENGTH  = 3'd5,
    CFG_SLEW_RATE    = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    MODE_GOAL = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;
    logic [15:0]        step_time;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] shoulder_pitch;
    logic signed [15:0] shoulder_yaw;
    logic signed [15:0] elbow_angle;
    logic               at_goal;
  } out_item_t;

  typedef enum logic [3:0] {
    M_NONE, M_DXX, M_DYY, M_DZZ, M_AA, M_CC, M_BB, M_AB, M_AC, M_RR, M_SLEW
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD
  } acc_op_e;

  typedef enum logic [2:0] {
    SQ_NONE, SQ_LD_DIST, SQ_LD_ACOS, SQ_STEP, SQ_ST_B, SQ_ST_S
  } sqrt_op_e;

  typedef enum logic [1:0] {
    DV_NONE, DV_LD, DV_STEP
  } div_op_e;

  typedef enum logic [2:0] {
    CD_NONE, CD_LD_PITCH, CD_LD_YAW, CD_LD_ACOS, CD_STEP
  } cordic_op_e;

  typedef enum logic [2:0] {
    SV_NONE, SV_Q1, SV_YAW, SV_Q2, SV_ELBOW
  } store_e;

  typedef enum logic [4:0] {
    S_IDLE, S_TICK_MUL, S_TICK_UPD,
    S_SQ_X, S_SQ_Y, S_SQ_Z, S_SQ_END,
    S_DIST_LD, S_DIST_RUN, S_DIST_ST,
    S_MUL_AA, S_MUL_CC, S_MUL_BB, S_MUL_AB, S_MUL_AC,
    S_Q1_LD, S_Q1_RUN, S_Q1_ST,
    S_YAW_LD, S_YAW_RUN, S_YAW_ST,
    S_AC_LD, S_AC_CHK, S_AC_DIV, S_AC_RR, S_AC_SQ_LD, S_AC_SQ, S_AC_SQ_ST,
    S_AC_CD_LD, S_AC_CD, S_AC_ST,
    S_RESP
  } state_e;

  typedef struct packed {
    logic             load;
    mul_sel_e         mul;
    acc_op_e          acc;
    sqrt_op_e         sq;
    div_op_e          dv;
    cordic_op_e       cd;
    logic [CNT_W-1:0] iter;
    logic             ac_load;
    logic             ac_sel;
    store_e           store;
    logic             tick_upd;
  } dp_cmd_t;

  typedef struct packed {
    logic ac_special;
  } dp_stat_t;

endpackage

>>> sv/ikslew_ctrl.sv
// Sequencer that steps the shared datapath units through goal and tick items.
module ikslew_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_mode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ikslew_pkg::dp_stat_t stat_i,
  output ikslew_pkg::dp_cmd_t  cmd_o
);

  localparam logic [ikslew_pkg::CNT_W-1:0] SQ_LAST =
    ikslew_pkg::CNT_W'(ikslew_pkg::SQRT_STEPS - 1);
  localparam logic [ikslew_pkg::CNT_W-1:0] DV_LAST =
    ikslew_pkg::CNT_W'(ikslew_pkg::DIV_STEPS - 1);
  localparam logic [ikslew_pkg::CNT_W-1:0] CD_LAST =
    ikslew_pkg::CNT_W'(ikslew_pkg::CORDIC_STEPS - 1);

  ikslew_pkg::state_e state_q, state_d;
  logic [ikslew_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic phase_q, phase_d;
  logic run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ikslew_pkg::S_IDLE;
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  assign run = (state_q == ikslew_pkg::S_DIST_RUN) || (state_q == ikslew_pkg::S_Q1_RUN) ||
               (state_q == ikslew_pkg::S_YAW_RUN) || (state_q == ikslew_pkg::S_AC_DIV) ||
               (state_q == ikslew_pkg::S_AC_SQ) || (state_q == ikslew_pkg::S_AC_CD);

  // Next state, iteration counter and acos phase.
  always_comb begin
    state_d = state_q;
    cnt_d   = run ? cnt_q + 1'b1 : '0;
    phase_d = phase_q;
    case (state_q)
      ikslew_pkg::S_IDLE: begin
        phase_d = 1'b0;
        if (in_valid_i) begin
          state_d = (in_mode_i == ikslew_pkg::MODE_TICK) ? ikslew_pkg::S_TICK_MUL
                                                          : ikslew_pkg::S_SQ_X;
        end
      end
      ikslew_pkg::S_TICK_MUL: state_d = ikslew_pkg::S_TICK_UPD;
      ikslew_pkg::S_TICK_UPD: state_d = ikslew_pkg::S_RESP;
      ikslew_pkg::S_SQ_X:     state_d = ikslew_pkg::S_SQ_Y;
      ikslew_pkg::S_SQ_Y:     state_d = ikslew_pkg::S_SQ_Z;
      ikslew_pkg::S_SQ_Z:     state_d = ikslew_pkg::S_SQ_END;
      ikslew_pkg::S_SQ_END:   state_d = ikslew_pkg::S_DIST_LD;
      ikslew_pkg::S_DIST_LD:  state_d = ikslew_pkg::S_DIST_RUN;
      ikslew_pkg::S_DIST_RUN: if (cnt_q == SQ_LAST) state_d = ikslew_pkg::S_DIST_ST;
      ikslew_pkg::S_DIST_ST:  state_d = ikslew_pkg::S_MUL_AA;
      ikslew_pkg::S_MUL_AA:   state_d = ikslew_pkg::S_MUL_CC;
      ikslew_pkg::S_MUL_CC:   state_d = ikslew_pkg::S_MUL_BB;
      ikslew_pkg::S_MUL_BB:   state_d = ikslew_pkg::S_MUL_AB;
      ikslew_pkg::S_MUL_AB:   state_d = ikslew_pkg::S_MUL_AC;
      ikslew_pkg::S_MUL_AC:   state_d = ikslew_pkg::S_Q1_LD;
      ikslew_pkg::S_Q1_LD:    state_d = ikslew_pkg::S_Q1_RUN;
      ikslew_pkg::S_Q1_RUN:   if (cnt_q == CD_LAST) state_d = ikslew_pkg::S_Q1_ST;
      ikslew_pkg::S_Q1_ST:    state_d = ikslew_pkg::S_YAW_LD;
      ikslew_pkg::S_YAW_LD:   state_d = ikslew_pkg::S_YAW_RUN;
      ikslew_pkg::S_YAW_RUN:  if (cnt_q == CD_LAST) state_d = ikslew_pkg::S_YAW_ST;
      ikslew_pkg::S_YAW_ST:   state_d = ikslew_pkg::S_AC_LD;
      ikslew_pkg::S_AC_LD:    state_d = ikslew_pkg::S_AC_CHK;
      ikslew_pkg::S_AC_CHK: begin
        state_d = stat_i.ac_special ? ikslew_pkg::S_AC_ST : ikslew_pkg::S_AC_DIV;
      end
      ikslew_pkg::S_AC_DIV:   if (cnt_q == DV_LAST) state_d = ikslew_pkg::S_AC_RR;
      ikslew_pkg::S_AC_RR:    state_d = ikslew_pkg::S_AC_SQ_LD;
      ikslew_pkg::S_AC_SQ_LD: state_d = ikslew_pkg::S_AC_SQ;
      ikslew_pkg::S_AC_SQ:    if (cnt_q == SQ_LAST) state_d = ikslew_pkg::S_AC_SQ_ST;
      ikslew_pkg::S_AC_SQ_ST: state_d = ikslew_pkg::S_AC_CD_LD;
      ikslew_pkg::S_AC_CD_LD: state_d = ikslew_pkg::S_AC_CD;
      ikslew_pkg::S_AC_CD:    if (cnt_q == CD_LAST) state_d = ikslew_pkg::S_AC_ST;
      ikslew_pkg::S_AC_ST: begin
        if (phase_q) begin
          state_d = ikslew_pkg::S_RESP;
        end else begin
          phase_d = 1'b1;
          state_d = ikslew_pkg::S_AC_LD;
        end
      end
      ikslew_pkg::S_RESP:     if (out_ready_i) state_d = ikslew_pkg::S_IDLE;
      default:                state_d = ikslew_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o       = '0;
    cmd_o.iter  = cnt_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ikslew_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ikslew_pkg::S_TICK_MUL: cmd_o.mul = ikslew_pkg::M_SLEW;
      ikslew_pkg::S_TICK_UPD: cmd_o.tick_upd = 1'b1;
      ikslew_pkg::S_SQ_X:     cmd_o.mul = ikslew_pkg::M_DXX;
      ikslew_pkg::S_SQ_Y: begin
        cmd_o.mul = ikslew_pkg::M_DYY;
        cmd_o.acc = ikslew_pkg::ACC_LOAD;
      end
      ikslew_pkg::S_SQ_Z: begin
        cmd_o.mul = ikslew_pkg::M_DZZ;
        cmd_o.acc = ikslew_pkg::ACC_ADD;
      end
      ikslew_pkg::S_SQ_END:   cmd_o.acc = ikslew_pkg::ACC_ADD;
      ikslew_pkg::S_DIST_LD:  cmd_o.sq = ikslew_pkg::SQ_LD_DIST;
      ikslew_pkg::S_DIST_RUN: cmd_o.sq = ikslew_pkg::SQ_STEP;
      ikslew_pkg::S_DIST_ST:  cmd_o.sq = ikslew_pkg::SQ_ST_B;
      ikslew_pkg::S_MUL_AA:   cmd_o.mul = ikslew_pkg::M_AA;
      ikslew_pkg::S_MUL_CC:   cmd_o.mul = ikslew_pkg::M_CC;
      ikslew_pkg::S_MUL_BB:   cmd_o.mul = ikslew_pkg::M_BB;
      ikslew_pkg::S_MUL_AB:   cmd_o.mul = ikslew_pkg::M_AB;
      ikslew_pkg::S_MUL_AC:   cmd_o.mul = ikslew_pkg::M_AC;
      ikslew_pkg::S_Q1_LD:    cmd_o.cd = ikslew_pkg::CD_LD_PITCH;
      ikslew_pkg::S_Q1_RUN:   cmd_o.cd = ikslew_pkg::CD_STEP;
      ikslew_pkg::S_Q1_ST:    cmd_o.store = ikslew_pkg::SV_Q1;
      ikslew_pkg::S_YAW_LD:   cmd_o.cd = ikslew_pkg::CD_LD_YAW;
      ikslew_pkg::S_YAW_RUN:  cmd_o.cd = ikslew_pkg::CD_STEP;
      ikslew_pkg::S_YAW_ST:   cmd_o.store = ikslew_pkg::SV_YAW;
      ikslew_pkg::S_AC_LD: begin
        cmd_o.ac_load = 1'b1;
        cmd_o.ac_sel  = phase_q;
      end
      ikslew_pkg::S_AC_CHK:   cmd_o.dv = ikslew_pkg::DV_LD;
      ikslew_pkg::S_AC_DIV:   cmd_o.dv = ikslew_pkg::DV_STEP;
      ikslew_pkg::S_AC_RR:    cmd_o.mul = ikslew_pkg::M_RR;
      ikslew_pkg::S_AC_SQ_LD: cmd_o.sq = ikslew_pkg::SQ_LD_ACOS;
      ikslew_pkg::S_AC_SQ:    cmd_o.sq = ikslew_pkg::SQ_STEP;
      ikslew_pkg::S_AC_SQ_ST: cmd_o.sq = ikslew_pkg::SQ_ST_S;
      ikslew_pkg::S_AC_CD_LD: cmd_o.cd = ikslew_pkg::CD_LD_ACOS;
      ikslew_pkg::S_AC_CD:    cmd_o.cd = ikslew_pkg::CD_STEP;
      ikslew_pkg::S_AC_ST: begin
        cmd_o.store = phase_q ? ikslew_pkg::SV_ELBOW : ikslew_pkg::SV_Q2;
      end
      ikslew_pkg::S_RESP:     out_valid_o = 1'b1;
      default:                cmd_o = '0;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < ikslew_pkg::CNT_W'(ikslew_pkg::TAB_LEN))
    else $error("iteration counter out of range");

  a_tick_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_mode_i) |=> ##1 (state_q == ikslew_pkg::S_TICK_UPD))
    else $error("tick item did not reach the update step");

  a_two_acos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ikslew_pkg::S_AC_ST && !phase_q) |=> (state_q == ikslew_pkg::S_AC_LD))
    else $error("elbow angle pass skipped");

endmodule

>>> sv/ikslew_dp.sv
// Datapath: registers, shared multiplier, square root, divider and CORDIC unit.
module ikslew_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  ikslew_pkg::in_item_t in_data_i,
  input  ikslew_pkg::dp_cmd_t  cmd_i,
  output ikslew_pkg::dp_stat_t stat_o,
  output ikslew_pkg::out_item_t out_data_o
);

  logic signed [15:0] base_x_q, base_y_q, base_z_q;
  logic [14:0] upper_q, fore_q, hand_q;
  logic [15:0] slew_q;

  logic signed [15:0] cur_pitch_q, cur_yaw_q, cur_elbow_q;
  logic signed [15:0] goal_pitch_q, goal_yaw_q, goal_elbow_q;

  logic signed [17:0] dx_q, dy_q, dz_q;
  logic [15:0] st_q;

  logic signed [18:0] ma, mb;
  logic signed [37:0] mp;
  logic signed [37:0] prod_q, acc_q, aa_q, cc_q, bb_q, ab_q, ac_q;

  logic [35:0] sv_q, sr_q, sbit_q;
  logic [36:0] sq_t;
  logic [17:0] b_q;
  logic [16:0] s_q;

  logic signed [39:0] top_q, bot_q, abs_top;
  logic spec_zero, spec_pi;
  logic [35:0] rem_q;
  logic [36:0] rem2, bot37;
  logic [15:0] mag_q;
  logic signed [16:0] r_s;

  logic signed [39:0] cx_q, cy_q, lx, ly, sx, sy;
  logic signed [23:0] cz_q, lz, tab, cd_ang, acos_val;
  logic cz0_q;

  logic signed [23:0] q1_q, qy_q, q2_q;
  logic signed [24:0] psum;
  logic [32:0] tsum;
  logic [16:0] step;

  function automatic logic signed [15:0] to_out(input logic signed [24:0] v);
    logic signed [24:0] t;
    t = v + 25'sd128;
    return 16'(t >>> 8);
  endfunction

  function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                              input logic signed [15:0] dst,
                                              input logic [16:0] stp);
    logic signed [16:0] d;
    logic [16:0] ad;
    d  = 17'(cur) - 17'(dst);
    ad = d[16] ? 17'(-d) : 17'(d);
    if (ad < stp) return dst;
    // The new angle lies between cur and dst, so the wrap of 16 bits is harmless.
    if (cur < dst) return 16'(cur + stp[15:0]);
    return 16'(cur - stp[15:0]);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q <= '0;
      base_y_q <= '0;
      base_z_q <= '0;
      upper_q  <= 15'd2048;
      fore_q   <= 15'd2048;
      hand_q   <= 15'd256;
      slew_q   <= 16'd6400;
    end else if (cfg_we_i) begin
      case (ikslew_pkg::cfg_idx_e'(cfg_index_i))
        ikslew_pkg::CFG_BASE_X:       base_x_q <= cfg_data_i;
        ikslew_pkg::CFG_BASE_Y:       base_y_q <= cfg_data_i;
        ikslew_pkg::CFG_BASE_Z:       base_z_q <= cfg_data_i;
        ikslew_pkg::CFG_UPPER_LENGTH: upper_q  <= cfg_data_i[14:0];
        ikslew_pkg::CFG_FORE_LENGTH:  fore_q   <= cfg_data_i[14:0];
        ikslew_pkg::CFG_HAND_LENGTH:  hand_q   <= cfg_data_i[14:0];
        ikslew_pkg::CFG_SLEW_RATE:    slew_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.mul)
      ikslew_pkg::M_DXX: begin ma = 19'(dx_q); mb = 19'(dx_q); end
      ikslew_pkg::M_DYY: begin ma = 19'(dy_q); mb = 19'(dy_q); end
      ikslew_pkg::M_DZZ: begin ma = 19'(dz_q); mb = 19'(dz_q); end
      ikslew_pkg::M_AA:  begin ma = {4'b0, upper_q}; mb = {4'b0, upper_q}; end
      ikslew_pkg::M_CC:  begin ma = {4'b0, fore_q}; mb = {4'b0, fore_q}; end
      ikslew_pkg::M_BB:  begin ma = {1'b0, b_q}; mb = {1'b0, b_q}; end
      ikslew_pkg::M_AB:  begin ma = {4'b0, upper_q}; mb = {1'b0, b_q}; end
      ikslew_pkg::M_AC:  begin ma = {4'b0, upper_q}; mb = {4'b0, fore_q}; end
      ikslew_pkg::M_RR:  begin ma = 19'(r_s); mb = 19'(r_s); end
      ikslew_pkg::M_SLEW: begin ma = {3'b0, slew_q}; mb = {3'b0, st_q}; end
      default: ;
    endcase
  end

  assign mp = ma * mb;

  // Square root step: one result bit per cycle.
  assign sq_t = {1'b0, sr_q} + {1'b0, sbit_q};

  // acos clamps and the restoring divide of |top| * 2^16 by bottom.
  assign spec_zero = (bot_q <= 40'sd0) || (top_q >= bot_q);
  assign spec_pi   = !spec_zero && (top_q <= -bot_q);
  assign stat_o.ac_special = spec_zero || spec_pi;
  assign abs_top = top_q[39] ? -top_q : top_q;
  assign rem2    = {rem_q, 1'b0};
  assign bot37   = 37'(bot_q);
  assign r_s     = top_q[39] ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

  // CORDIC load values, pre-rotated by a quarter turn when x is negative.
  always_comb begin
    lx = '0;
    ly = '0;
    case (cmd_i.cd)
      ikslew_pkg::CD_LD_PITCH: begin ly = 40'(dy_q) <<< 16; lx = 40'(dz_q) <<< 16; end
      ikslew_pkg::CD_LD_YAW:   begin ly = 40'(dx_q) <<< 16; lx = 40'(dz_q) <<< 16; end
      ikslew_pkg::CD_LD_ACOS: begin
        ly = $signed(40'(s_q)) <<< 16;
        lx = 40'(r_s) <<< 16;
      end
      default: ;
    endcase
  end

  assign sx  = cx_q >>> cmd_i.iter;
  assign sy  = cy_q >>> cmd_i.iter;
  assign tab = $signed({4'b0, ikslew_pkg::ATAN_TAB[cmd_i.iter]});
  assign lz  = (ly >= 40'sd0) ? ikslew_pkg::ANG_90 : -ikslew_pkg::ANG_90;

  assign cd_ang   = cz0_q ? 24'sd0 : cz_q;
  assign acos_val = spec_zero ? 24'sd0 : (spec_pi ? ikslew_pkg::ANG_180 : cd_ang);
  assign psum     = -(25'(q1_q) + 25'(q2_q));

  assign tsum = {1'b0, prod_q[31:0]} + 33'd32768;
  assign step = tsum[32:16];

  // Working registers of the goal computation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q <= 18'(in_data_i.target_x) - 18'(base_x_q);
      dy_q <= 18'(in_data_i.target_y) - 18'(base_y_q) + ikslew_pkg::Y_OFFSET;
      dz_q <= 18'(in_data_i.target_z) - 18'(base_z_q) - $signed({3'b0, hand_q});
      st_q <= in_data_i.step_time;
    end

    case (cmd_i.mul)
      ikslew_pkg::M_AA: aa_q <= mp;
      ikslew_pkg::M_CC: cc_q <= mp;
      ikslew_pkg::M_BB: bb_q <= mp;
      ikslew_pkg::M_AB: ab_q <= mp;
      ikslew_pkg::M_AC: ac_q <= mp;
      ikslew_pkg::M_NONE: ;
      default: prod_q <= mp;
    endcase

    case (cmd_i.acc)
      ikslew_pkg::ACC_LOAD: acc_q <= prod_q;
      ikslew_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
      default: ;
    endcase

    case (cmd_i.sq)
      ikslew_pkg::SQ_LD_DIST: begin
        sv_q   <= acc_q[35:0];
        sr_q   <= '0;
        sbit_q <= 36'd1 << 34;
      end
      ikslew_pkg::SQ_LD_ACOS: begin
        sv_q   <= 36'(38'sh01_0000_0000 - prod_q);
        sr_q   <= '0;
        sbit_q <= 36'd1 << 34;
      end
      ikslew_pkg::SQ_STEP: begin
        if ({1'b0, sv_q} >= sq_t) begin
          sv_q <= sv_q - sq_t[35:0];
          sr_q <= (sr_q >> 1) + sbit_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      ikslew_pkg::SQ_ST_B: b_q <= sr_q[17:0];
      ikslew_pkg::SQ_ST_S: s_q <= sr_q[16:0];
      default: ;
    endcase

    if (cmd_i.ac_load) begin
      if (cmd_i.ac_sel) begin
        top_q <= 40'(aa_q) + 40'(cc_q) - 40'(bb_q);
        bot_q <= 40'(ac_q) + 40'(ac_q);
      end else begin
        top_q <= 40'(aa_q) + 40'(bb_q) - 40'(cc_q);
        bot_q <= 40'(ab_q) + 40'(ab_q);
      end
    end

    case (cmd_i.dv)
      ikslew_pkg::DV_LD: begin
        rem_q <= abs_top[35:0];
        mag_q <= '0;
      end
      ikslew_pkg::DV_STEP: begin
        if (rem2 >= bot37) begin
          rem_q <= 36'(rem2 - bot37);
          mag_q <= {mag_q[14:0], 1'b1};
        end else begin
          rem_q <= rem2[35:0];
          mag_q <= {mag_q[14:0], 1'b0};
        end
      end
      default: ;
    endcase

    case (cmd_i.cd)
      ikslew_pkg::CD_STEP: begin
        if (cy_q > 40'sd0) begin
          cx_q <= cx_q + sy;
          cy_q <= cy_q - sx;
          cz_q <= cz_q + tab;
        end else begin
          cx_q <= cx_q - sy;
          cy_q <= cy_q + sx;
          cz_q <= cz_q - tab;
        end
      end
      ikslew_pkg::CD_NONE: ;
      default: begin
        cz0_q <= (lx == 40'sd0) && (ly == 40'sd0);
        if (lx < 40'sd0) begin
          cx_q <= (ly >= 40'sd0) ? ly : -ly;
          cy_q <= (ly >= 40'sd0) ? -lx : lx;
          cz_q <= lz;
        end else begin
          cx_q <= lx;
          cy_q <= ly;
          cz_q <= '0;
        end
      end
    endcase

    case (cmd_i.store)
      ikslew_pkg::SV_Q1:  q1_q <= cd_ang;
      ikslew_pkg::SV_YAW: qy_q <= cd_ang;
      ikslew_pkg::SV_Q2:  q2_q <= acos_val;
      default: ;
    endcase
  end

  // Joint angle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pitch_q  <= '0;
      cur_yaw_q    <= '0;
      cur_elbow_q  <= '0;
      goal_pitch_q <= '0;
      goal_yaw_q   <= '0;
      goal_elbow_q <= '0;
    end else begin
      if (cmd_i.store == ikslew_pkg::SV_ELBOW) begin
        goal_pitch_q <= to_out(psum);
        goal_yaw_q   <= to_out(25'(qy_q));
        goal_elbow_q <= to_out(25'(acos_val));
      end
      if (cmd_i.tick_upd) begin
        cur_pitch_q <= slew(cur_pitch_q, goal_pitch_q, step);
        cur_yaw_q   <= slew(cur_yaw_q, goal_yaw_q, step);
        cur_elbow_q <= slew(cur_elbow_q, goal_elbow_q, step);
      end
    end
  end

  assign out_data_o.shoulder_pitch = cur_pitch_q;
  assign out_data_o.shoulder_yaw   = cur_yaw_q;
  assign out_data_o.elbow_angle    = cur_elbow_q;
  assign out_data_o.at_goal        = (cur_pitch_q == goal_pitch_q) &&
                                     (cur_yaw_q == goal_yaw_q) &&
                                     (cur_elbow_q == goal_elbow_q);

endmodule

>>> sv/two_link_arm_ik_slew.sv
// Top level of the two-link arm joint controller: sequencer plus datapath.
// One item is handled at a time and each gives one result beat. A tick beat
// passes through a multiply state and an update state before its result is
// offered. A goal beat runs the shared units in turn: a square root for the
// distance, five products, two CORDIC passes for pitch and yaw, then two law of
// cosines passes, each a divide, a square root and one more CORDIC pass unless
// its cosine ratio clamps. The next beat is taken in the cycle after the result
// beat leaves. Configuration writes are always taken at once and should only be
// made while the block is idle.
module two_link_arm_ik_slew (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ikslew_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ikslew_pkg::out_item_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);

  ikslew_pkg::dp_cmd_t  cmd;
  ikslew_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ikslew_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_data_i.mode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ikslew_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

>>> test/two_link_arm_ik_slew_checker.sv
// Checker for the two-link arm joint controller: predicts each result beat and compares it.
`timescale 1ns / 100ps
module two_link_arm_ik_slew_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  ikslew_pkg::in_item_t  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  ikslew_pkg::out_item_t out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam longint FINE_90 = 90 * 16384;

  longint arm_base_x, arm_base_y, arm_base_z;
  longint len_upper, len_fore, len_hand, rate;
  longint pos_pitch, pos_yaw, pos_elbow;
  longint aim_pitch, aim_yaw, aim_elbow;
  ikslew_pkg::out_item_t angle_q[$];

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_root(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint z, t;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = FINE_90;
      end else begin
        x = -y; y = t; z = -FINE_90;
      end
    end
    for (int i = 0; i < ikslew_pkg::CORDIC_STEPS && i < ikslew_pkg::TAB_LEN; i++) begin
      if (y > 0) begin
        t = x + shr_floor(y, i); y = y - shr_floor(x, i); x = t;
        z = z + longint'(ikslew_pkg::ATAN_TAB[i]);
      end else begin
        t = x - shr_floor(y, i); y = y + shr_floor(x, i); x = t;
        z = z - longint'(ikslew_pkg::ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint cosine_law_angle(longint top, longint bottom);
    longint mag, r;
    if (bottom <= 0 || top >= bottom) return 0;
    if (top <= -bottom) return 2 * FINE_90;
    mag = ((top < 0 ? -top : top) <<< 16) / bottom;
    r = top < 0 ? -mag : mag;
    return cordic_atan2(int_root((64'sd1 <<< 32) - r * r), r);
  endfunction

  function automatic longint to_deg64(longint fine);
    return (fine + 128) >>> 8;
  endfunction

  function automatic longint slew_toward(longint cur, longint dst, longint step);
    longint d;
    d = cur - dst;
    if (d < 0) d = -d;
    if (d < step) return dst;
    return cur < dst ? cur + step : cur - step;
  endfunction

  task automatic predict_angles(ikslew_pkg::in_item_t it);
    longint dx, dy, dz, b, q1, q2, step;
    ikslew_pkg::out_item_t res;
    if (it.mode == ikslew_pkg::MODE_GOAL) begin
      dx = longint'(it.target_x) - arm_base_x;
      dy = longint'(it.target_y) - arm_base_y + 51;
      dz = longint'(it.target_z) - arm_base_z - len_hand;
      b = int_root(dx * dx + dy * dy + dz * dz);
      q1 = cordic_atan2(dy, dz);
      q2 = cosine_law_angle(len_upper * len_upper + b * b - len_fore * len_fore,
                            2 * len_upper * b);
      aim_pitch = to_deg64(-(q1 + q2));
      aim_yaw = to_deg64(cordic_atan2(dx, dz));
      aim_elbow = to_deg64(cosine_law_angle(
          len_upper * len_upper + len_fore * len_fore - b * b, 2 * len_upper * len_fore));
    end else begin
      step = (rate * longint'(it.step_time) + 32768) >>> 16;
      pos_pitch = slew_toward(pos_pitch, aim_pitch, step);
      pos_yaw = slew_toward(pos_yaw, aim_yaw, step);
      pos_elbow = slew_toward(pos_elbow, aim_elbow, step);
    end
    res.shoulder_pitch = pos_pitch[15:0];
    res.shoulder_yaw = pos_yaw[15:0];
    res.elbow_angle = pos_elbow[15:0];
    res.at_goal = (pos_pitch == aim_pitch && pos_yaw == aim_yaw && pos_elbow == aim_elbow);
    angle_q.push_back(res);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = angle_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    ikslew_pkg::out_item_t want;
    if (!rst_ni) begin
      arm_base_x = 0; arm_base_y = 0; arm_base_z = 0;
      len_upper = 2048; len_fore = 2048; len_hand = 256; rate = 6400;
      pos_pitch = 0; pos_yaw = 0; pos_elbow = 0;
      aim_pitch = 0; aim_yaw = 0; aim_elbow = 0;
      fail_count_o = 0;
      angle_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (ikslew_pkg::cfg_idx_e'(cfg_index_i))
          ikslew_pkg::CFG_BASE_X:       arm_base_x = longint'($signed(cfg_data_i));
          ikslew_pkg::CFG_BASE_Y:       arm_base_y = longint'($signed(cfg_data_i));
          ikslew_pkg::CFG_BASE_Z:       arm_base_z = longint'($signed(cfg_data_i));
          ikslew_pkg::CFG_UPPER_LENGTH: len_upper = longint'(cfg_data_i[14:0]);
          ikslew_pkg::CFG_FORE_LENGTH:  len_fore = longint'(cfg_data_i[14:0]);
          ikslew_pkg::CFG_HAND_LENGTH:  len_hand = longint'(cfg_data_i[14:0]);
          ikslew_pkg::CFG_SLEW_RATE:    rate = longint'(cfg_data_i);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (angle_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          fail_count_o++;
        end else begin
          want = angle_q.pop_front();
          if (out_data_i.shoulder_pitch !== want.shoulder_pitch)
            report_mismatch("shoulder_pitch", out_data_i.shoulder_pitch, want.shoulder_pitch);
          if (out_data_i.shoulder_yaw !== want.shoulder_yaw)
            report_mismatch("shoulder_yaw", out_data_i.shoulder_yaw, want.shoulder_yaw);
          if (out_data_i.elbow_angle !== want.elbow_angle)
            report_mismatch("elbow_angle", out_data_i.elbow_angle, want.elbow_angle);
          if (out_data_i.at_goal !== want.at_goal)
            report_mismatch("at_goal", out_data_i.at_goal, want.at_goal);
        end
      end
      // The expectation is pushed after the pop, so a beat is never matched against itself.
      if (in_valid_i && in_ready_i) predict_angles(in_data_i);
    end
  end
endmodule

>>> test/two_link_arm_ik_slew_tb.sv
// Testbench top of the two-link arm joint controller: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module two_link_arm_ik_slew_tb;

  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  ikslew_pkg::in_item_t in_data = '0;
  logic out_valid, out_ready = 1'b0;
  ikslew_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int fail_count, pending;
  int send_idle_pct = 0, recv_stall_pct = 0;
  longint cycles = 0;

  always #10 clk = ~clk;

  two_link_arm_ik_slew i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  two_link_arm_ik_slew_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("[two_link_arm_ik_slew] ERROR");
      $finish;
    end
  end

  // Valid drops after each beat; the block stays busy for longer than this gap.
  task automatic send_beat(ikslew_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(ikslew_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic ikslew_pkg::in_item_t goal_beat(logic [15:0] x, logic [15:0] y,
                                                     logic [15:0] z);
    ikslew_pkg::in_item_t it;
    it = '0;
    it.mode = ikslew_pkg::MODE_GOAL;
    it.target_x = x; it.target_y = y; it.target_z = z;
    it.step_time = 16'($urandom);
    return it;
  endfunction

  function automatic ikslew_pkg::in_item_t tick_beat(logic [15:0] t);
    ikslew_pkg::in_item_t it;
    it = '0;
    it.target_x = 16'($urandom); it.target_y = 16'($urandom); it.target_z = 16'($urandom);
    it.mode = ikslew_pkg::MODE_TICK;
    it.step_time = t;
    return it;
  endfunction

  // Targets near the arm's reach so that the cosine ratios mostly stay inside [-1,1].
  function automatic logic [15:0] near_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 2048)) - 1024);
      default: return 16'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0)
        send_beat(goal_beat(near_coord(), near_coord(), near_coord()));
      else if ($urandom_range(7) == 0)
        send_beat(tick_beat(16'($urandom)));
      else
        send_beat(tick_beat(16'($urandom_range(0, 4096))));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, the clamped ratios, a zero hand length and small ticks.
    send_beat(goal_beat(16'h0000, 16'h0000, 16'h0000));
    send_beat(tick_beat(16'h0000));
    send_beat(tick_beat(16'h0001));
    send_beat(tick_beat(16'hFFFF));
    send_beat(goal_beat(16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_beat(goal_beat(16'h8000, 16'h8000, 16'h8000));
    send_beat(tick_beat(16'hFFFF));
    send_beat(goal_beat(16'h0000, 16'hFFCD, 16'h0100));
    send_beat(goal_beat(16'h0000, 16'hFFCD, 16'h0F00));
    send_beat(goal_beat(16'h8000, 16'h0000, 16'h0100));
    send_beat(goal_beat(16'h0400, 16'h0000, 16'h0100));
    send_beat(tick_beat(16'h8000));
    send_beat(tick_beat(16'h8000));
    drain();
    write_reg(ikslew_pkg::CFG_UPPER_LENGTH, 16'h0001);
    write_reg(ikslew_pkg::CFG_FORE_LENGTH, 16'h7FFF);
    write_reg(ikslew_pkg::CFG_HAND_LENGTH, 16'h0000);
    write_reg(ikslew_pkg::CFG_SLEW_RATE, 16'hFFFF);
    write_reg(ikslew_pkg::CFG_BASE_X, 16'h7FFF);
    write_reg(ikslew_pkg::CFG_BASE_Y, 16'h8000);
    write_reg(ikslew_pkg::CFG_BASE_Z, 16'h8000);
    send_beat(goal_beat(16'h8000, 16'h7FFF, 16'h7FFF));
    send_beat(goal_beat(16'h7FFF, 16'h8033, 16'h8000));
    send_beat(tick_beat(16'hFFFF));
    drain();
    write_reg(ikslew_pkg::CFG_SLEW_RATE, 16'h0000);
    send_beat(tick_beat(16'hFFFF));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      case (ph)
        0: begin
          write_reg(ikslew_pkg::CFG_BASE_X, 16'h0000);
          write_reg(ikslew_pkg::CFG_BASE_Y, 16'h0000);
          write_reg(ikslew_pkg::CFG_BASE_Z, 16'h0000);
          write_reg(ikslew_pkg::CFG_UPPER_LENGTH, 16'd2048);
          write_reg(ikslew_pkg::CFG_FORE_LENGTH, 16'd2048);
          write_reg(ikslew_pkg::CFG_HAND_LENGTH, 16'd256);
          write_reg(ikslew_pkg::CFG_SLEW_RATE, 16'd6400);
        end
        3: begin
          write_reg(ikslew_pkg::CFG_HAND_LENGTH, 16'h7FFF);
          write_reg(ikslew_pkg::CFG_SLEW_RATE, 16'hFFFF);
        end
        5: begin
          write_reg(ikslew_pkg::CFG_UPPER_LENGTH, 16'h0001);
          write_reg(ikslew_pkg::CFG_FORE_LENGTH, 16'h0001);
          write_reg(ikslew_pkg::CFG_HAND_LENGTH, 16'h0000);
        end
        default: begin
          write_reg(ikslew_pkg::CFG_BASE_X, 16'($signed($urandom_range(0, 1024)) - 512));
          write_reg(ikslew_pkg::CFG_BASE_Y, 16'($signed($urandom_range(0, 1024)) - 512));
          write_reg(ikslew_pkg::CFG_BASE_Z, 16'($signed($urandom_range(0, 1024)) - 512));
          write_reg(ikslew_pkg::CFG_UPPER_LENGTH, 16'($urandom_range(64, 4096)));
          write_reg(ikslew_pkg::CFG_FORE_LENGTH, 16'($urandom_range(64, 4096)));
          write_reg(ikslew_pkg::CFG_HAND_LENGTH, 16'($urandom_range(0, 1024)));
          write_reg(ikslew_pkg::CFG_SLEW_RATE, 16'($urandom));
        end
      endcase
      random_phase(228);
      drain();
    end

    if (fail_count == 0) begin
      $display("[two_link_arm_ik_slew] OK");
    end else begin
      $display("[two_link_arm_ik_slew] ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
sv/ikslew_pkg.sv
sv/ikslew_ctrl.sv
sv/ikslew_dp.sv
sv/two_link_arm_ik_slew.sv
test/two_link_arm_ik_slew_checker.sv
test/two_link_arm_ik_slew_tb.sv
